// ===== rtl/core/keyboard_lock_filter_macros.svh =====
// Assertion macros for the keyboard lock filter RTL.
// Included by keyboard_lock_filter, the module that carries concurrent assertions; no other dependencies.
`ifndef KEYBOARD_LOCK_FILTER_MACROS_SVH
`define KEYBOARD_LOCK_FILTER_MACROS_SVH

`ifndef ASSERT_OFF
// Overlapping implication: when ante holds, cons holds in the same cycle.
`define KLF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyboard_lock_filter: same-cycle check failed");
// Next-cycle implication: when ante holds, cons holds in the cycle after.
`define KLF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyboard_lock_filter: next-cycle check failed");
`else
`define KLF_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KLF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/klf_pkg.sv =====
// Shared types and constants for the keyboard lock filter.
// No dependencies; imported by every module of the block.
package klf_pkg;

    localparam int SEQ_W   = 64;
    localparam int LEN_W   = 4;
    localparam int CODE_W  = 8;
    localparam int CHAR_W  = 8;
    localparam int MATCH_W = 3;
    localparam int MOD_W   = 4;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_SEQUENCE_DEF = 8;

    localparam logic [SEQ_W-1:0]  SEQ_RESET    = 64'h0000_4B43_4F4C_4E55; // "UNLOCK"
    localparam logic [LEN_W-1:0]  LEN_RESET    = 4'd6;
    localparam logic [CODE_W-1:0] HOTKEY_RESET = 8'h4C;                    // 'L'

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEQUENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOTKEY   = 2'd2;

    typedef enum logic [1:0] {
        FUNC_KEY         = 2'd0,
        FUNC_LOCK_ON     = 2'd1,
        FUNC_LOCK_OFF    = 2'd2,
        FUNC_LOCK_TOGGLE = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [CODE_W-1:0] key_code;
        logic [CHAR_W-1:0] key_char;
        logic              key_up;
    } t_in_item;

    typedef struct packed {
        logic block_key;
        logic locked;
        logic lock_changed;
    } t_out_item;

    // Live configuration, length already clamped to the legal range
    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [LEN_W-1:0]  eff_len;
        logic [CODE_W-1:0] hotkey;
    } t_cfg;

    typedef struct packed {
        logic               lock;
        logic [MATCH_W-1:0] match_count;
        logic [MOD_W-1:0]   mods;
        logic               armed;
    } t_state;

endpackage

// ===== rtl/core/keyboard_lock_filter.sv =====
// Top level of the keyboard lock filter: input register, update logic, result register.
// Depends on klf_pkg, klf_cfg, klf_update and keyboard_lock_filter_macros.svh.
//
//  Channel   Signals                                   Carries
//  -------   ---------------------------------------   ---------------------------
//  in        i_in_valid / o_in_ready / i_in_item       key event or lock command
//  out       o_out_valid / i_out_ready / o_out_item    block, locked, changed
//  cfg       i_cfg_we / i_cfg_index / i_cfg_data       register write, no wait
//
// Each item passes through the input register and then the result register.
// One item transfers per cycle in steady state while i_out_ready holds; the state
// registers update when an item moves from the input register to the result register.
// Reset is synchronous and active low; it clears the valid flags, the filter
// state and returns the configuration registers to their defaults.
// A stall on the output holds the result register, then fills the input
// register; o_in_ready drops only when both are full.
`include "keyboard_lock_filter_macros.svh"

module keyboard_lock_filter import klf_pkg::*; #(
    parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SEQ_W-1:0]     i_cfg_data
);

    t_cfg      cfg;
    t_state    r_state;
    t_state    n_state;
    t_in_item  r_in;
    logic      r_in_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      r_out_valid;
    logic      advance;

    klf_cfg #(
        .MAX_SEQUENCE(MAX_SEQUENCE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    klf_update u_update (
        .i_item   (r_in),
        .i_state  (r_state),
        .i_cfg    (cfg),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Move the held item into the result register whenever that slot is free
    // or is being emptied this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Payload register: load on every transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Filter state commits together with the result of the item that changed it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `KLF_ASSERT_NEXT(a_locked_tracks_state, i_clk, i_rst_n, advance,
        r_out.locked == r_state.lock)
    `KLF_ASSERT_NEXT(a_changed_matches_edge, i_clk, i_rst_n, advance,
        r_out.lock_changed == (r_state.lock != $past(r_state.lock)))
    `KLF_ASSERT_SAME(a_block_only_locked, i_clk, i_rst_n, advance && n_out.block_key,
        r_state.lock)
    `KLF_ASSERT_SAME(a_stall_needs_item, i_clk, i_rst_n, !o_in_ready,
        r_in_valid && r_out_valid)

endmodule

// ===== rtl/core/klf_cfg.sv =====
// Configuration registers of the keyboard lock filter.
// Depends on klf_pkg; clamps the unlock length to 1..MAX_SEQUENCE.
module klf_cfg import klf_pkg::*; #(
    parameter int MAX_SEQUENCE = MAX_SEQUENCE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SEQ_W-1:0]     i_cfg_data,
    output t_cfg                 o_cfg
);

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SEQUENCE);

    logic [SEQ_W-1:0]  r_seq;
    logic [LEN_W-1:0]  r_len;
    logic [CODE_W-1:0] r_hotkey;
    logic [LEN_W-1:0]  eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq    <= SEQ_RESET;
            r_len    <= LEN_RESET;
            r_hotkey <= HOTKEY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SEQUENCE: r_seq    <= i_cfg_data;
                CFG_LENGTH:   r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_HOTKEY:   r_hotkey <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_MAX) begin
            eff_len = LEN_MAX;
        end else begin
            eff_len = r_len;
        end
    end

    assign o_cfg = '{seq: r_seq, eff_len: eff_len, hotkey: r_hotkey};

endmodule

// ===== rtl/core/klf_update.sv =====
// Per-item update of the lock state, unlock match and modifier tracking.
// Depends on klf_pkg; purely combinational, registered by the top level.
module klf_update import klf_pkg::*; (
    input  t_in_item  i_item,
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    output t_state    o_state,
    output t_out_item o_result
);

    localparam logic [CODE_W-1:0] WL_LO = 8'hAD;   // mute
    localparam logic [CODE_W-1:0] WL_HI = 8'hB3;   // play/pause
    localparam logic [MOD_W-1:0]  MOD_ALT   = 4'b0001;
    localparam logic [MOD_W-1:0]  MOD_CTRL  = 4'b0010;
    localparam logic [MOD_W-1:0]  MOD_SHIFT = 4'b0100;
    localparam logic [MOD_W-1:0]  MOD_WIN   = 4'b1000;

    logic               whitelisted;
    logic               block;
    logic [MOD_W-1:0]   mod_bit;
    logic [CHAR_W-1:0]  want;
    logic [LEN_W-1:0]   next_idx;
    t_state             n_state;

    assign whitelisted = (i_item.key_code >= WL_LO) && (i_item.key_code <= WL_HI);
    assign want        = i_cfg.seq[{i_state.match_count, 3'b000} +: CHAR_W];
    assign next_idx    = {1'b0, i_state.match_count} + LEN_W'(1);

    always_comb begin
        case (i_item.key_code) inside
            8'hA4, 8'hA5: mod_bit = MOD_ALT;
            8'hA2, 8'hA3: mod_bit = MOD_CTRL;
            8'hA0, 8'hA1: mod_bit = MOD_SHIFT;
            8'h5B, 8'h5C: mod_bit = MOD_WIN;
            default:      mod_bit = '0;
        endcase
    end

    always_comb begin
        n_state = i_state;
        block   = 1'b0;
        unique case (i_item.func)
            FUNC_LOCK_ON:     n_state.lock = 1'b1;
            FUNC_LOCK_OFF:    n_state.lock = 1'b0;
            FUNC_LOCK_TOGGLE: n_state.lock = ~i_state.lock;
            FUNC_KEY: begin
                block = i_state.lock && !whitelisted;
                if (block) begin
                    // swallowed press: advance or restart the unlock match, unlocking when it completes
                    if (!i_item.key_up) begin
                        if (i_item.key_char == want) begin
                            if (next_idx >= i_cfg.eff_len) begin
                                n_state.lock        = 1'b0;
                                n_state.match_count = '0;
                            end else begin
                                n_state.match_count = next_idx[MATCH_W-1:0];
                            end
                        end else begin
                            n_state.match_count = '0;
                        end
                    end
                end else begin
                    if (i_item.key_up) begin
                        n_state.mods = i_state.mods & ~mod_bit;
                    end else begin
                        n_state.mods = i_state.mods | mod_bit;
                    end
                    if ((n_state.mods == (MOD_CTRL | MOD_ALT)) &&
                        (i_item.key_code == i_cfg.hotkey) && !i_item.key_up) begin
                        n_state.armed = 1'b1;
                    end
                    if ((n_state.mods == '0) && n_state.armed) begin
                        n_state.armed = 1'b0;
                        n_state.lock  = 1'b1;
                    end
                end
            end
        endcase
    end

    assign o_state  = n_state;
    assign o_result = '{block_key:    block,
                        locked:       n_state.lock,
                        lock_changed: n_state.lock ^ i_state.lock};

endmodule
